// File: src/gelk_pkg.sv
// Shared types and constants for the Gaussian-times-exponential likelihood scorer.
// Used by gelk_einv_cell, gelk_density and the top level; depends on nothing.
package gelk_pkg;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] duration;
  } gelk_req_t;

  typedef struct packed {
    logic [31:0] score;
    logic        was_floored;
  } gelk_res_t;

  typedef enum logic [2:0] {
    CFG_GAUSS_CENTER   = 3'd0,
    CFG_GAUSS_VARIANCE = 3'd1,
    CFG_EXP_ONSET      = 3'd2,
    CFG_EXP_SCALE      = 3'd3,
    CFG_FLOOR_SCORE    = 3'd4
  } gelk_cfg_idx_t;

  // quotient bits of the argument division, and of the density division
  localparam int unsigned QBITS1       = 21;
  localparam int unsigned QBITS2       = 49;
  localparam int unsigned SERIES_TERMS = 12;
  localparam int unsigned EINV_STEPS   = 22;
  localparam int unsigned SQRT_STEPS   = 25;

  localparam logic [4:0]  EXP_MAX_INT = 5'd22;
  localparam logic [30:0] E_INV_Q32   = 31'd1580030169;
  localparam logic [26:0] TWO_PI_Q24  = 27'd105414357;
  localparam logic [32:0] Q32_ONE     = 33'h1_0000_0000;

endpackage

// File: src/gelk_div_cell.sv
// One restoring division step: shifts in one dividend bit, yields one quotient bit.
// Standalone cell; chained by gelk_density.
module gelk_div_cell #(
  parameter int NB = 21,
  parameter int QW = 21,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   divisor,
  input  logic          valid_in,
  input  logic [31:0]   rem_in,
  input  logic [NB-1:0] bits_in,
  input  logic [QW-1:0] quo_in,
  input  logic [SW-1:0] side_in,
  output logic          valid_out,
  output logic [31:0]   rem_out,
  output logic [NB-1:0] bits_out,
  output logic [QW-1:0] quo_out,
  output logic [SW-1:0] side_out
);

  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        ge;

  assign rem_sh = {rem_in, bits_in[NB-1]};
  assign ge     = rem_sh >= {1'b0, divisor};
  assign diff   = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_out  <= ge ? diff[31:0] : rem_sh[31:0];
    bits_out <= {bits_in[NB-2:0], 1'b0};
    quo_out  <= {quo_in[QW-2:0], ge};
    side_out <= side_in;
  end

endmodule

// File: src/gelk_exp_cell.sv
// One Taylor term of exp(-f): multiply by f, then divide by the term index K.
// Standalone two-register cell; chained by gelk_density.
module gelk_exp_cell #(
  parameter int K  = 1,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid_in,
  input  logic [31:0]   f_in,
  input  logic [32:0]   term_in,
  input  logic [32:0]   sum_in,
  input  logic [4:0]    n_in,
  input  logic [SW-1:0] side_in,
  output logic          valid_out,
  output logic [31:0]   f_out,
  output logic [32:0]   term_out,
  output logic [32:0]   sum_out,
  output logic [4:0]    n_out,
  output logic [SW-1:0] side_out
);

  // floor(x / K) == (x * RECIP) >> 37 for every x below 2^33
  localparam logic [37:0] RECIP    = 38'(((64'd1 << 37) / K) + 64'd1);
  localparam bit          SUBTRACT = (K % 2) == 1;

  logic          a_valid;
  logic [31:0]   a_f;
  logic [32:0]   a_x;
  logic [32:0]   a_sum;
  logic [4:0]    a_n;
  logic [SW-1:0] a_side;
  logic [64:0]   prod;
  logic [70:0]   qprod;
  logic [32:0]   term_new;

  assign prod     = term_in * f_in;
  assign qprod    = a_x * RECIP;
  assign term_new = qprod[69:37];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      a_valid   <= valid_in;
      valid_out <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_f      <= f_in;
    a_x      <= prod[64:32];
    a_sum    <= sum_in;
    a_n      <= n_in;
    a_side   <= side_in;
    f_out    <= a_f;
    term_out <= term_new;
    sum_out  <= SUBTRACT ? a_sum - term_new : a_sum + term_new;
    n_out    <= a_n;
    side_out <= a_side;
  end

endmodule

// File: src/gelk_einv_cell.sv
// One rounded multiply by e^-1 in Q0.32, applied when the integer part exceeds I.
// Uses gelk_pkg; chained by gelk_density.
module gelk_einv_cell
  import gelk_pkg::*;
#(
  parameter int I  = 0,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid_in,
  input  logic [32:0]   r_in,
  input  logic [4:0]    n_in,
  input  logic [SW-1:0] side_in,
  output logic          valid_out,
  output logic [32:0]   r_out,
  output logic [4:0]    n_out,
  output logic [SW-1:0] side_out
);

  localparam logic [4:0] IDX = 5'(I);

  logic [64:0] rounded;

  assign rounded = 65'(r_in) * 65'(E_INV_Q32) + (65'd1 << 31);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    r_out    <= (n_in > IDX) ? rounded[64:32] : r_in;
    n_out    <= n_in;
    side_out <= side_in;
  end

endmodule

// File: src/gelk_sqrt_cell.sv
// One digit step of the integer square root (bit pairs from the top down).
// Standalone cell; chained by the top level.
module gelk_sqrt_cell #(
  parameter int I = 0
) (
  input  logic        clk,
  input  logic [49:0] rem_in,
  input  logic [49:0] res_in,
  output logic [49:0] rem_out,
  output logic [49:0] res_out
);

  localparam logic [49:0] BIT = 50'd1 << (48 - 2 * I);

  logic [50:0] trial;
  logic        ge;

  assign trial = {1'b0, res_in} + {1'b0, BIT};
  assign ge    = {1'b0, rem_in} >= trial;

  always_ff @(posedge clk) begin
    rem_out <= ge ? 50'({1'b0, rem_in} - trial) : rem_in;
    res_out <= ge ? (res_in >> 1) + BIT : res_in >> 1;
  end

endmodule

// File: src/gelk_density.sv
// One density branch: argument division, exp(-x) series, e^-1 steps, final division.
// Uses gelk_pkg and the div, exp and einv cells.
module gelk_density
  import gelk_pkg::*;
#(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   div_a,
  input  logic [31:0]   div_b,
  input  logic          valid_in,
  input  logic [31:0]   rem_in,
  input  logic [20:0]   bits_in,
  input  logic [SW-1:0] side_in,
  output logic          valid_out,
  output logic [48:0]   quo_out,
  output logic [SW-1:0] side_out
);

  logic          d1_valid [QBITS1+1];
  logic [31:0]   d1_rem   [QBITS1+1];
  logic [20:0]   d1_bits  [QBITS1+1];
  logic [20:0]   d1_quo   [QBITS1+1];
  logic [SW-1:0] d1_side  [QBITS1+1];

  logic          ex_valid [SERIES_TERMS+1];
  logic [31:0]   ex_f     [SERIES_TERMS+1];
  logic [32:0]   ex_term  [SERIES_TERMS+1];
  logic [32:0]   ex_sum   [SERIES_TERMS+1];
  logic [4:0]    ex_n     [SERIES_TERMS+1];
  logic [SW-1:0] ex_side  [SERIES_TERMS+1];

  logic          ei_valid [EINV_STEPS+1];
  logic [32:0]   ei_r     [EINV_STEPS+1];
  logic [4:0]    ei_n     [EINV_STEPS+1];
  logic [SW-1:0] ei_side  [EINV_STEPS+1];

  logic          d2_valid [QBITS2+1];
  logic [31:0]   d2_rem   [QBITS2+1];
  logic [48:0]   d2_bits  [QBITS2+1];
  logic [48:0]   d2_quo   [QBITS2+1];
  logic [SW-1:0] d2_side  [QBITS2+1];

  assign d1_valid[0] = valid_in;
  assign d1_rem[0]   = rem_in;
  assign d1_bits[0]  = bits_in;
  assign d1_quo[0]   = '0;
  assign d1_side[0]  = side_in;

  for (genvar i = 0; i < QBITS1; i++) begin : g_div1
    gelk_div_cell #(.NB(21), .QW(21), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .divisor  (div_a),
      .valid_in (d1_valid[i]),
      .rem_in   (d1_rem[i]),
      .bits_in  (d1_bits[i]),
      .quo_in   (d1_quo[i]),
      .side_in  (d1_side[i]),
      .valid_out(d1_valid[i+1]),
      .rem_out  (d1_rem[i+1]),
      .bits_out (d1_bits[i+1]),
      .quo_out  (d1_quo[i+1]),
      .side_out (d1_side[i+1])
    );
  end

  // split the Q5.16 argument into integer part and Q0.32 fraction
  assign ex_valid[0] = d1_valid[QBITS1];
  assign ex_f[0]     = {d1_quo[QBITS1][15:0], 16'd0};
  assign ex_n[0]     = d1_quo[QBITS1][20:16];
  assign ex_term[0]  = Q32_ONE;
  assign ex_sum[0]   = Q32_ONE;
  assign ex_side[0]  = d1_side[QBITS1];

  for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_series
    gelk_exp_cell #(.K(k + 1), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (ex_valid[k]),
      .f_in     (ex_f[k]),
      .term_in  (ex_term[k]),
      .sum_in   (ex_sum[k]),
      .n_in     (ex_n[k]),
      .side_in  (ex_side[k]),
      .valid_out(ex_valid[k+1]),
      .f_out    (ex_f[k+1]),
      .term_out (ex_term[k+1]),
      .sum_out  (ex_sum[k+1]),
      .n_out    (ex_n[k+1]),
      .side_out (ex_side[k+1])
    );
  end

  // a zero start stays zero through the e^-1 steps
  assign ei_valid[0] = ex_valid[SERIES_TERMS];
  assign ei_r[0]     = (ex_n[SERIES_TERMS] > EXP_MAX_INT) ? 33'd0 : ex_sum[SERIES_TERMS];
  assign ei_n[0]     = ex_n[SERIES_TERMS];
  assign ei_side[0]  = ex_side[SERIES_TERMS];

  for (genvar j = 0; j < EINV_STEPS; j++) begin : g_einv
    gelk_einv_cell #(.I(j), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (ei_valid[j]),
      .r_in     (ei_r[j]),
      .n_in     (ei_n[j]),
      .side_in  (ei_side[j]),
      .valid_out(ei_valid[j+1]),
      .r_out    (ei_r[j+1]),
      .n_out    (ei_n[j+1]),
      .side_out (ei_side[j+1])
    );
  end

  assign d2_valid[0] = ei_valid[EINV_STEPS];
  assign d2_rem[0]   = '0;
  assign d2_bits[0]  = {ei_r[EINV_STEPS], 16'd0};
  assign d2_quo[0]   = '0;
  assign d2_side[0]  = ei_side[EINV_STEPS];

  for (genvar i = 0; i < QBITS2; i++) begin : g_div2
    gelk_div_cell #(.NB(49), .QW(49), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .divisor  (div_b),
      .valid_in (d2_valid[i]),
      .rem_in   (d2_rem[i]),
      .bits_in  (d2_bits[i]),
      .quo_in   (d2_quo[i]),
      .side_in  (d2_side[i]),
      .valid_out(d2_valid[i+1]),
      .rem_out  (d2_rem[i+1]),
      .bits_out (d2_bits[i+1]),
      .quo_out  (d2_quo[i+1]),
      .side_out (d2_side[i+1])
    );
  end

  assign valid_out = d2_valid[QBITS2];
  assign quo_out   = d2_quo[QBITS2];
  assign side_out  = d2_side[QBITS2];

endmodule

// File: src/gauss_exp_likelihood_score.sv
// Top level of the Gaussian-times-exponential likelihood scorer.
// Uses gelk_pkg, gelk_density and gelk_sqrt_cell.
//
// Scores one request (position, duration) per clock: start is taken in any cycle
// and busy is always low. Each request comes out as a single-cycle done strobe
// with result; there is no backpressure, so the receiver must take it then.
// The pipeline is made of 2 entry stages, 21 argument division cells, 12 two-stage
// series cells, 22 e^-1 cells, 49 density division cells and 4 product and rounding
// stages. Write configuration only with no request in flight.
module gauss_exp_likelihood_score
  import gelk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  gelk_req_t   request,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output gelk_res_t   result
);

  logic signed [31:0] gauss_center;
  logic [30:0]        gauss_variance;
  logic signed [31:0] exp_onset;
  logic [30:0]        exp_scale;
  logic [31:0]        floor_score;

  logic [30:0] var_eff;
  logic [30:0] scale_eff;
  logic [31:0] two_var;

  logic [57:0] sq_prod;
  logic [49:0] sq_rem [SQRT_STEPS+1];
  logic [49:0] sq_res [SQRT_STEPS+1];
  logic [24:0] sq_root;

  logic signed [32:0] pos_diff;
  logic signed [32:0] dur_diff;
  logic [32:0]        pos_neg;

  logic        st1_valid;
  logic [31:0] st1_mag;
  logic [31:0] st1_x;
  logic        st1_neg;
  logic        st2_valid;
  logic [63:0] st2_d2;
  logic [31:0] st2_x;
  logic        st2_neg;

  logic        g_floored_in;
  logic        e_zero_in;
  logic        g_valid;
  logic        e_valid;
  logic [48:0] g_quo;
  logic [48:0] e_quo;
  logic        g_floored;
  logic        e_zero;

  logic        pa_valid;
  logic        pa_floored;
  logic        pa_zero;
  logic [49:0] pa_ll;
  logic [48:0] pa_lh;
  logic [48:0] pa_hl;
  logic [47:0] pa_hh;
  logic        pb_valid;
  logic        pb_floored;
  logic        pb_zero;
  logic [49:0] pb_ll;
  logic [49:0] pb_mid;
  logic [47:0] pb_hh;
  logic        pc_valid;
  logic        pc_floored;
  logic        pc_zero;
  logic [97:0] pc_full;

  logic [32:0] rounded;
  logic [31:0] score_sat;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gauss_center   <= '0;
      gauss_variance <= 31'd65536;
      exp_onset      <= '0;
      exp_scale      <= 31'd65536;
      floor_score    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gelk_cfg_idx_t'(cfg_index))
        CFG_GAUSS_CENTER:   gauss_center   <= cfg_data;
        CFG_GAUSS_VARIANCE: gauss_variance <= cfg_data[30:0];
        CFG_EXP_ONSET:      exp_onset      <= cfg_data;
        CFG_EXP_SCALE:      exp_scale      <= cfg_data[30:0];
        CFG_FLOOR_SCORE:    floor_score    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign var_eff   = (gauss_variance == '0) ? 31'd1 : gauss_variance;
  assign scale_eff = (exp_scale == '0) ? 31'd1 : exp_scale;
  assign two_var   = {var_eff, 1'b0};

  // sqrt(2*pi*variance) runs free off the registers; it settles long before use
  always_ff @(posedge clk) begin
    sq_prod <= var_eff * TWO_PI_Q24;
    sq_root <= (sq_res[SQRT_STEPS][24:0] == '0) ? 25'd1 : sq_res[SQRT_STEPS][24:0];
  end

  assign sq_rem[0] = sq_prod[57:8];
  assign sq_res[0] = '0;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    gelk_sqrt_cell #(.I(i)) u_cell (
      .clk    (clk),
      .rem_in (sq_rem[i]),
      .res_in (sq_res[i]),
      .rem_out(sq_rem[i+1]),
      .res_out(sq_res[i+1])
    );
  end

  assign pos_diff = 33'(request.position) - 33'(gauss_center);
  assign dur_diff = 33'(request.duration) - 33'(exp_onset);
  assign pos_neg  = -pos_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
    end else begin
      st1_valid <= start && !busy;
      st2_valid <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    st1_mag <= pos_diff[32] ? pos_neg[31:0] : pos_diff[31:0];
    st1_x   <= dur_diff[31:0];
    st1_neg <= dur_diff[32];
    st2_d2  <= st1_mag * st1_mag;
    st2_x   <= st1_x;
    st2_neg <= st1_neg;
  end

  // outside the cutoff when d^2 exceeds 2*variance in Q32.32
  assign g_floored_in = st2_d2 > {16'd0, two_var, 16'd0};
  // an argument of 2^21 or more has integer part beyond the exp range
  assign e_zero_in    = st2_neg || ({5'd0, st2_x[31:5]} >= {1'b0, scale_eff});

  gelk_density #(.SW(1)) u_gauss (
    .clk      (clk),
    .rst      (rst),
    .div_a    (two_var),
    .div_b    ({7'd0, sq_root}),
    .valid_in (st2_valid),
    .rem_in   (st2_d2[52:21]),
    .bits_in  (st2_d2[20:0]),
    .side_in  (g_floored_in),
    .valid_out(g_valid),
    .quo_out  (g_quo),
    .side_out (g_floored)
  );

  gelk_density #(.SW(1)) u_expo (
    .clk      (clk),
    .rst      (rst),
    .div_a    ({1'b0, scale_eff}),
    .div_b    ({1'b0, scale_eff}),
    .valid_in (st2_valid),
    .rem_in   ({5'd0, st2_x[31:5]}),
    .bits_in  ({st2_x[4:0], 16'd0}),
    .side_in  (e_zero_in),
    .valid_out(e_valid),
    .quo_out  (e_quo),
    .side_out (e_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_valid <= 1'b0;
      pb_valid <= 1'b0;
      pc_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      pa_valid <= g_valid && e_valid;
      pb_valid <= pa_valid;
      pc_valid <= pb_valid;
      done     <= pc_valid;
    end
  end

  assign rounded   = {1'b0, pc_full[79:48]} + {32'd0, pc_full[47]};
  assign score_sat = ((pc_full[97:80] != '0) || rounded[32]) ? 32'hFFFF_FFFF : rounded[31:0];

  // partial products, then their sum, then round and saturate, or give the floor score or zero
  always_ff @(posedge clk) begin
    pa_floored <= g_floored;
    pa_zero    <= e_zero;
    pa_ll      <= g_quo[24:0] * e_quo[24:0];
    pa_lh      <= g_quo[24:0] * e_quo[48:25];
    pa_hl      <= g_quo[48:25] * e_quo[24:0];
    pa_hh      <= g_quo[48:25] * e_quo[48:25];
    pb_floored <= pa_floored;
    pb_zero    <= pa_zero;
    pb_ll      <= pa_ll;
    pb_mid     <= {1'b0, pa_lh} + {1'b0, pa_hl};
    pb_hh      <= pa_hh;
    pc_floored <= pb_floored;
    pc_zero    <= pb_zero;
    pc_full    <= {pb_hh, 50'd0} + {23'd0, pb_mid, 25'd0} + {48'd0, pb_ll};
    result.was_floored <= pc_floored;
    if (pc_floored) begin
      result.score <= floor_score;
    end else if (pc_zero) begin
      result.score <= '0;
    end else begin
      result.score <= score_sat;
    end
  end

endmodule
